### sv/tijm_pkg.sv
// Shared types, register map and helpers of the tick interval jitter monitor.
// Used by tijm_div and tick_interval_jitter_monitor_core; depends on nothing.
package tijm_pkg;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RATE_START,
        ST_RATE_WAIT,
        ST_ACCUM,
        ST_CHECK,
        ST_AVG_START,
        ST_AVG_WAIT,
        ST_MUL,
        ST_VAR,
        ST_SQRT,
        ST_SD_START,
        ST_SD_WAIT,
        ST_EMIT
    } tijm_state_t;

    localparam logic [2:0] ADDR_REPORT_RATE = 3'd0;
    localparam logic [9:0] REPORT_RATE_RESET = 10'd1;

    localparam int DIV_W      = 64;
    localparam int DIVISOR_W  = 32;
    localparam int COUNT_W    = 20;
    localparam int PROD_W     = 84;
    localparam int RAD_W      = 100;
    localparam int ROOT_W     = 50;

    function automatic logic [31:0] sat32(input logic [63:0] v);
        logic [31:0] r;
        r = (v[63:32] != 32'd0) ? 32'hFFFF_FFFF : v[31:0];
        return r;
    endfunction

endpackage

### sv/tijm_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, 64 by 32 bits.
// Depends on tijm_pkg for widths.
module tijm_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [tijm_pkg::DIV_W-1:0]     dividend,
    input  logic [tijm_pkg::DIVISOR_W-1:0] divisor,
    output logic                           done,
    output logic [tijm_pkg::DIV_W-1:0]     quotient
);
    import tijm_pkg::*;

    logic [DIV_W-1:0]     q_reg, q_next;
    logic [DIVISOR_W-1:0] rem_reg, rem_next;
    logic [DIVISOR_W-1:0] dvs_reg;
    logic [6:0]           cnt_reg, cnt_next;
    logic                 done_reg, done_next;
    logic [DIVISOR_W:0]   shifted;
    logic [DIVISOR_W:0]   diff;

    always_comb
    begin
        shifted   = {rem_reg, q_reg[DIV_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next   = dividend;
            rem_next = '0;
            cnt_next = 7'(DIV_W);
        end
        else if (cnt_reg != 7'd0)
        begin
            cnt_next = cnt_reg - 7'd1;
            if (!diff[DIVISOR_W])
            begin
                rem_next = diff[DIVISOR_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DIVISOR_W-1:0];
                q_next   = {q_reg[DIV_W-2:0], 1'b0};
            end
            done_next = (cnt_reg == 7'd1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        if (start)
            dvs_reg <= divisor;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

### sv/tick_interval_jitter_monitor_core.sv
// Top level of the tick interval jitter monitor: handshakes, window
// accumulators, bit-serial multiply and square root. Uses tijm_pkg, tijm_div.
//
//   channel   dir   handshake              payload
//   s_*       in    s_tvalid / s_tready    s_tdata: delta_time_us
//   m_*       out   m_tvalid / m_tready    m_tdata: rates and stddev, m_tuser: flag
//   apb       in    psel, penable, pready  report_rate_hz at address 0
//
// An item that does not close a window goes through the rate division.
// One that closes a window adds the mean division, a serial multiply, a
// square root and the stddev division. Reset is asynchronous and clears
// control state and the window. A stalled result waits in the output
// register and only holds the last step of the next item.
module tick_interval_jitter_monitor_core #(
    parameter int UNITS_PER_SECOND = 1000000
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] delta_time_us
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,   // [31:0] last_rate, [63:32] average_rate,
                                   // [95:64] jitter_stddev
    output logic        m_tuser,   // [0] window_closed
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tijm_pkg::*;

    localparam logic [63:0] RATE_NUM = 64'(UNITS_PER_SECOND) * 64'd4096;
    localparam logic [41:0] UNITS    = 42'(UNITS_PER_SECOND);

    tijm_state_t state_reg, state_next;

    logic [9:0]          rate_hz_reg;
    logic [23:0]         dt_reg;
    logic [47:0]         dtsq_reg;
    logic [COUNT_W-1:0]  cnt_reg;
    logic [31:0]         sum_reg;
    logic [63:0]         sumsq_reg;
    logic [31:0]         held_avg_reg;
    logic [31:0]         held_sd_reg;
    logic [31:0]         last_rate_reg;
    logic                closed_reg;
    logic [63:0]         num_reg;
    logic [63:0]         sumsq2_reg;
    logic [PROD_W-1:0]   acc_reg;
    logic [COUNT_W-1:0]  mbits_reg;
    logic [4:0]          mstep_reg;
    logic [RAD_W-1:0]    rad_reg;
    logic [ROOT_W+1:0]   rem_reg;
    logic [ROOT_W-1:0]   root_reg;
    logic [5:0]          sstep_reg;
    logic                m_tvalid_reg;
    logic [95:0]         m_tdata_reg;
    logic                m_tuser_reg;

    logic                div_start;
    logic [63:0]         div_dividend;
    logic [31:0]         div_divisor;
    logic                div_done;
    logic [63:0]         div_q;

    logic                in_fire;
    logic                apb_write;
    logic                emit;
    logic [32:0]         sum_add;
    logic [64:0]         sumsq_add;
    logic [41:0]         close_prod;
    logic [ROOT_W+1:0]   rem_sh;
    logic [ROOT_W+1:0]   trial;
    logic [PROD_W-1:0]   variance;

    assign in_fire   = s_tvalid && s_tready;
    assign apb_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_REPORT_RATE) ? {22'd0, rate_hz_reg} : 32'd0;
    assign s_tready  = (state_reg == ST_IDLE);
    assign emit      = (state_reg == ST_EMIT) && (!m_tvalid_reg || m_tready);

    assign sum_add    = {1'b0, sum_reg} + {9'd0, dt_reg};
    assign sumsq_add  = {1'b0, sumsq_reg} + {17'd0, dtsq_reg};
    assign close_prod = 42'(sum_reg) * 42'(rate_hz_reg);
    assign rem_sh     = {rem_reg[ROOT_W-1:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial      = {root_reg, 2'b01};
    assign variance   = (acc_reg > PROD_W'(sumsq2_reg)) ? acc_reg - PROD_W'(sumsq2_reg)
                                                        : '0;

    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = RATE_NUM;
        div_divisor  = {8'd0, dt_reg};
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire && s_tdata != 24'd0 && rate_hz_reg != 10'd0)
                    state_next = ST_RATE_START;
            end
            ST_RATE_START:
            begin
                div_start  = 1'b1;
                state_next = ST_RATE_WAIT;
            end
            ST_RATE_WAIT:
            begin
                if (div_done)
                    state_next = ST_ACCUM;
            end
            ST_ACCUM:
                state_next = ST_CHECK;
            ST_CHECK:
                state_next = (close_prod >= UNITS) ? ST_AVG_START : ST_EMIT;
            ST_AVG_START:
            begin
                div_start    = 1'b1;
                div_dividend = num_reg;
                div_divisor  = sum_reg;
                state_next   = ST_AVG_WAIT;
            end
            ST_AVG_WAIT:
            begin
                if (div_done)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mstep_reg == 5'd1)
                    state_next = ST_VAR;
            end
            ST_VAR:
                state_next = ST_SQRT;
            ST_SQRT:
            begin
                if (sstep_reg == 6'd1)
                    state_next = ST_SD_START;
            end
            ST_SD_START:
            begin
                div_start    = 1'b1;
                div_dividend = {{(64-ROOT_W){1'b0}}, root_reg};
                div_divisor  = {12'd0, cnt_reg};
                state_next   = ST_SD_WAIT;
            end
            ST_SD_WAIT:
            begin
                div_dividend = {{(64-ROOT_W){1'b0}}, root_reg};
                div_divisor  = {12'd0, cnt_reg};
                if (div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_hz_reg  <= REPORT_RATE_RESET;
            cnt_reg      <= '0;
            sum_reg      <= '0;
            sumsq_reg    <= '0;
            held_avg_reg <= '0;
            held_sd_reg  <= '0;
            closed_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (apb_write && paddr == ADDR_REPORT_RATE)
                rate_hz_reg <= pwdata[9:0];
            case (state_reg)
                ST_ACCUM:
                begin
                    closed_reg <= 1'b0;
                    if (cnt_reg != {COUNT_W{1'b1}})
                        cnt_reg <= cnt_reg + 1'b1;
                    sum_reg   <= sum_add[32] ? 32'hFFFF_FFFF : sum_add[31:0];
                    sumsq_reg <= sumsq_add[64] ? {64{1'b1}} : sumsq_add[63:0];
                end
                ST_AVG_WAIT:
                begin
                    if (div_done)
                        held_avg_reg <= sat32(div_q);
                end
                ST_SD_WAIT:
                begin
                    if (div_done)
                    begin
                        held_sd_reg <= sat32(div_q);
                        closed_reg  <= 1'b1;
                        cnt_reg     <= '0;
                        sum_reg     <= '0;
                        sumsq_reg   <= '0;
                    end
                end
                default:
                begin
                end
            endcase
            if (emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    // Datapath registers; the serial multiply walks the count from its MSB.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && in_fire)
        begin
            dt_reg   <= s_tdata;
            dtsq_reg <= 48'(s_tdata) * 48'(s_tdata);
        end
        if (state_reg == ST_RATE_WAIT && div_done)
            last_rate_reg <= sat32(div_q);
        if (state_reg == ST_CHECK)
        begin
            num_reg    <= 64'(RATE_NUM * 64'(cnt_reg));
            sumsq2_reg <= 64'(sum_reg) * 64'(sum_reg);
            acc_reg    <= '0;
            mbits_reg  <= cnt_reg;
            mstep_reg  <= 5'(COUNT_W);
        end
        if (state_reg == ST_MUL)
        begin
            acc_reg   <= {acc_reg[PROD_W-2:0], 1'b0}
                         + (mbits_reg[COUNT_W-1] ? PROD_W'(sumsq_reg) : '0);
            mbits_reg <= {mbits_reg[COUNT_W-2:0], 1'b0};
            mstep_reg <= mstep_reg - 5'd1;
        end
        if (state_reg == ST_VAR)
        begin
            rad_reg   <= {variance, 16'd0};
            rem_reg   <= '0;
            root_reg  <= '0;
            sstep_reg <= 6'(ROOT_W);
        end
        if (state_reg == ST_SQRT)
        begin
            rad_reg   <= {rad_reg[RAD_W-3:0], 2'b00};
            sstep_reg <= sstep_reg - 6'd1;
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (emit)
        begin
            m_tdata_reg <= {held_sd_reg, held_avg_reg, last_rate_reg};
            m_tuser_reg <= closed_reg;
        end
    end

    tijm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_close_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && closed_reg) |-> (cnt_reg == '0 && sum_reg == '0))
        else $error("window closed without clearing the accumulators");

    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && s_tdata != 24'd0 && rate_hz_reg != 10'd0) |=> state_reg == ST_RATE_START)
        else $error("valid interval did not start processing");

    a_sqrt_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SQRT) |-> (sstep_reg != 6'd0))
        else $error("square root ran past its last step");

endmodule
